// ===== sv/edp_pkg.sv =====
// Shared constants and types for the EBML doctype probe.
`default_nettype none

package edp_pkg;

  // Largest length descriptor accepted by default (EBML allows up to eight bytes).
  localparam int MAX_LENGTH_BYTES_DEF = 8;

  localparam logic [31:0] EBML_MAGIC = 32'h1A45_DFA3;
  localparam logic [63:0] DOC_LONG   = 64'h6D61_7472_6F73_6B61;  // "matroska"
  localparam logic [31:0] DOC_SHORT  = 32'h7765_626D;            // "webm"

  localparam int SIZE_W = 56;
  localparam int WIN_W  = 64;

  localparam logic [1:0] VERDICT_REJECT = 2'd0;
  localparam logic [1:0] VERDICT_EBML   = 2'd1;
  localparam logic [1:0] VERDICT_MKV    = 2'd2;

  typedef enum logic [4:0] {
    PH_MAGIC     = 5'b00001,
    PH_LEN_FIRST = 5'b00010,
    PH_LEN_REST  = 5'b00100,
    PH_BODY      = 5'b01000,
    PH_DONE      = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

// ===== sv/ebml_doctype_probe_core.sv =====
// Top level of the EBML header probe: magic check, size decode and doctype scan.
//
// Usage: the file's leading bytes enter one per beat on the in_ channel
// (in_data_byte, with in_last_byte high on the final byte of a probe). The
// block checks the EBML magic, decodes the variable-length header size and
// scans the header body for "matroska" or "webm". It delivers at most one
// verdict per probe on the out_ channel: 0 not matroska, 1 EBML header with
// an unknown doctype, 2 matroska or webm. The verdict appears as soon as it
// is decided, or with the final byte. Bytes after a verdict give no beat.
// Throughput is one byte per cycle unless a held verdict stalls input; a verdict
// is valid the cycle after its deciding byte. Each byte passes through a single
// layer of logic (window shift, two compares, a 56-bit decrement and zero
// test) between the probe state registers and the result register.
// A single result register sits on the output: while it holds an untaken
// verdict and out_ready is low, in_ready is low and input stalls; as soon
// as the verdict is taken a new byte is accepted in the same cycle.
// Synchronous reset (rst_n low) returns the probe to the magic check and
// empties the result register.
`default_nettype none

module ebml_doctype_probe_core #(
  parameter int MAX_LENGTH_BYTES = edp_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_verdict
);

  localparam int LenW = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;

  edp_pkg::phase_t                phase_r, phase_nxt;
  logic [1:0]                     magic_pos_r, magic_pos_nxt;
  logic [LenW-1:0]                len_left_r, len_left_nxt;
  logic [edp_pkg::SIZE_W-1:0]     hdr_left_r, hdr_left_nxt;
  logic [edp_pkg::WIN_W-1:0]      window_r, window_nxt;
  logic [3:0]                     seen_r, seen_nxt;
  logic                           doctype_r, doctype_nxt;
  logic                           out_valid_r;
  logic [1:0]                     out_verdict_r;

  logic                           in_fire;
  logic                           res_valid;
  logic [1:0]                     res_verdict;
  logic                           enter_body;
  logic [7:0]                     magic_byte;
  logic                           lead_found;
  logic [2:0]                     lead_pos;
  logic                           lead_ok;
  logic [7:0]                     body_mask;

  assign in_ready    = ~out_valid_r | out_ready;
  assign in_fire     = in_valid & in_ready;
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  assign magic_byte = edp_pkg::EBML_MAGIC[{~magic_pos_r, 3'b000} +: 8];

  // Leading one of the first length byte, counted from the top bit.
  always_comb begin
    lead_found = 1'b0;
    lead_pos   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!lead_found && in_data_byte[7-i]) begin
        lead_found = 1'b1;
        lead_pos   = 3'(i);
      end
    end
  end

  assign lead_ok   = lead_found && (32'(lead_pos) < 32'(MAX_LENGTH_BYTES));
  assign body_mask = 8'h7F >> lead_pos;

  always_comb begin
    phase_nxt     = phase_r;
    magic_pos_nxt = magic_pos_r;
    len_left_nxt  = len_left_r;
    hdr_left_nxt  = hdr_left_r;
    window_nxt    = window_r;
    seen_nxt      = seen_r;
    doctype_nxt   = doctype_r;
    res_valid     = 1'b0;
    res_verdict   = edp_pkg::VERDICT_REJECT;
    enter_body    = 1'b0;

    case (phase_r)
      edp_pkg::PH_MAGIC: begin
        if (in_data_byte != magic_byte) begin
          res_valid = 1'b1;
          phase_nxt = edp_pkg::PH_DONE;
        end else if (magic_pos_r == 2'd3) begin
          phase_nxt = edp_pkg::PH_LEN_FIRST;
        end else begin
          magic_pos_nxt = magic_pos_r + 2'd1;
        end
      end
      edp_pkg::PH_LEN_FIRST: begin
        if (!lead_ok) begin
          res_valid = 1'b1;
          phase_nxt = edp_pkg::PH_DONE;
        end else begin
          hdr_left_nxt = {{(edp_pkg::SIZE_W-8){1'b0}}, in_data_byte & body_mask};
          len_left_nxt = LenW'(lead_pos);
          if (lead_pos == 3'd0) begin
            enter_body = 1'b1;
          end else begin
            phase_nxt = edp_pkg::PH_LEN_REST;
          end
        end
      end
      edp_pkg::PH_LEN_REST: begin
        hdr_left_nxt = {hdr_left_r[edp_pkg::SIZE_W-9:0], in_data_byte};
        if (len_left_r != '0) begin
          len_left_nxt = len_left_r - LenW'(1);
        end
        if (len_left_nxt == '0) begin
          enter_body = 1'b1;
        end
      end
      edp_pkg::PH_BODY: begin
        window_nxt = {window_r[edp_pkg::WIN_W-9:0], in_data_byte};
        if (seen_r < 4'd8) begin
          seen_nxt = seen_r + 4'd1;
        end
        if (seen_nxt >= 4'd8 && window_nxt == edp_pkg::DOC_LONG) begin
          doctype_nxt = 1'b1;
        end
        if (seen_nxt >= 4'd4 && window_nxt[31:0] == edp_pkg::DOC_SHORT) begin
          doctype_nxt = 1'b1;
        end
        if (hdr_left_r != '0) begin
          hdr_left_nxt = hdr_left_r - {{(edp_pkg::SIZE_W-1){1'b0}}, 1'b1};
        end
        if (hdr_left_nxt == '0) begin
          res_valid   = 1'b1;
          res_verdict = doctype_nxt ? edp_pkg::VERDICT_MKV : edp_pkg::VERDICT_EBML;
          phase_nxt   = edp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // On the last length byte the doctype scan is cleared; an empty header body is decided on that byte.
    if (enter_body) begin
      window_nxt  = '0;
      seen_nxt    = 4'd0;
      doctype_nxt = 1'b0;
      if (hdr_left_nxt == '0) begin
        res_valid   = 1'b1;
        res_verdict = edp_pkg::VERDICT_EBML;
        phase_nxt   = edp_pkg::PH_DONE;
      end else begin
        phase_nxt = edp_pkg::PH_BODY;
      end
    end

    // The final byte closes the probe: an undecided probe is rejected.
    if (in_last_byte) begin
      if (!res_valid && phase_nxt != edp_pkg::PH_DONE) begin
        res_valid   = 1'b1;
        res_verdict = edp_pkg::VERDICT_REJECT;
      end
      phase_nxt     = edp_pkg::PH_MAGIC;
      magic_pos_nxt = 2'd0;
      len_left_nxt  = '0;
      hdr_left_nxt  = '0;
      window_nxt    = '0;
      seen_nxt      = 4'd0;
      doctype_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= edp_pkg::PH_MAGIC;
      magic_pos_r <= 2'd0;
      len_left_r  <= '0;
      seen_r      <= 4'd0;
      doctype_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      magic_pos_r <= magic_pos_nxt;
      len_left_r  <= len_left_nxt;
      seen_r      <= seen_nxt;
      doctype_r   <= doctype_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdr_left_r <= hdr_left_nxt;
      window_r   <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_fire & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_verdict_r <= res_verdict;
    end
  end

`ifndef SYNTH
  a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == edp_pkg::PH_BODY) |-> (hdr_left_r != '0))
    else $error("header body entered with no bytes left");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=> (phase_r == edp_pkg::PH_MAGIC && magic_pos_r == 2'd0))
    else $error("probe did not restart after the final byte");

  a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= 4'd8)
    else $error("header byte count passed its saturation point");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == edp_pkg::PH_DONE) |=> !out_valid_r)
    else $error("verdict given for a byte after the probe was decided");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the EBML doctype probe: byte stream in, one verdict per probe out.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_LEN = edp_pkg::MAX_LENGTH_BYTES_DEF;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_verdict;

  ebml_doctype_probe_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_verdict  (out_verdict)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Probe state as the block should hold it.
  edp_pkg::phase_t probe_phase;
  logic [1:0]  magic_idx;
  logic [3:0]  len_left;
  logic [55:0] body_left;
  logic [63:0] body_window;
  logic [3:0]  body_seen;
  logic        doc_seen;

  logic [1:0]  pending_verdicts[$];
  logic [7:0]  probe_buf[$];
  logic [1:0]  want_verdict;
  int          err_count;
  int          bytes_sent;
  int          probes_sent;
  int          verdict_tally[0:3];
  bit          steady;
  bit          sender_calm;

  function automatic void clear_probe();
    probe_phase = edp_pkg::PH_MAGIC;
    magic_idx   = 2'd0;
    len_left    = 4'd0;
    body_left   = 56'd0;
    body_window = 64'd0;
    body_seen   = 4'd0;
    doc_seen    = 1'b0;
  endfunction

  function automatic bit open_header_body(output logic [1:0] v);
    body_window = 64'd0;
    body_seen   = 4'd0;
    doc_seen    = 1'b0;
    v = edp_pkg::VERDICT_EBML;
    if (body_left == 56'd0) begin
      probe_phase = edp_pkg::PH_DONE;
      return 1'b1;
    end
    probe_phase = edp_pkg::PH_BODY;
    return 1'b0;
  endfunction

  function automatic bit predict_verdict(input logic [7:0] b, input logic last,
                                         output logic [1:0] v);
    bit         has;
    int         lead;
    logic [7:0] mask;
    has  = 1'b0;
    v    = edp_pkg::VERDICT_REJECT;
    lead = 0;
    case (probe_phase)
      edp_pkg::PH_MAGIC: begin
        if (b != edp_pkg::EBML_MAGIC[8 * (3 - magic_idx) +: 8]) begin
          has = 1'b1;
          v = edp_pkg::VERDICT_REJECT;
          probe_phase = edp_pkg::PH_DONE;
        end else if (magic_idx == 2'd3) begin
          probe_phase = edp_pkg::PH_LEN_FIRST;
        end else begin
          magic_idx++;
        end
      end
      edp_pkg::PH_LEN_FIRST: begin
        for (int i = 0; i < 8; i++)
          if (lead == 0 && b[7 - i]) lead = i + 1;
        if (lead == 0 || lead > MAX_LEN) begin
          has = 1'b1;
          v = edp_pkg::VERDICT_REJECT;
          probe_phase = edp_pkg::PH_DONE;
        end else begin
          mask = (8'h80 >> (lead - 1)) - 8'd1;
          body_left = {48'd0, b & mask};
          len_left = 4'(lead - 1);
          if (len_left == 4'd0) has = open_header_body(v);
          else probe_phase = edp_pkg::PH_LEN_REST;
        end
      end
      edp_pkg::PH_LEN_REST: begin
        body_left = {body_left[47:0], b};
        if (len_left != 4'd0) len_left--;
        if (len_left == 4'd0) has = open_header_body(v);
      end
      edp_pkg::PH_BODY: begin
        body_window = {body_window[55:0], b};
        if (body_seen < 4'd8) body_seen++;
        if (body_seen >= 4'd8 && body_window == edp_pkg::DOC_LONG) doc_seen = 1'b1;
        if (body_seen >= 4'd4 && body_window[31:0] == edp_pkg::DOC_SHORT) doc_seen = 1'b1;
        if (body_left != 56'd0) body_left--;
        if (body_left == 56'd0) begin
          has = 1'b1;
          v = doc_seen ? edp_pkg::VERDICT_MKV : edp_pkg::VERDICT_EBML;
          probe_phase = edp_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
    // A probe that stops before any verdict is rejected on its final byte.
    if (last) begin
      if (!has && probe_phase != edp_pkg::PH_DONE) begin
        has = 1'b1;
        v = edp_pkg::VERDICT_REJECT;
      end
      clear_probe();
    end
    return has;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic [1:0] v;
    if (!steady && !sender_calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (predict_verdict(b, last, v)) pending_verdicts.push_back(v);
  endtask

  task automatic flush_probe();
    int cnt;
    cnt = probe_buf.size();
    for (int i = 0; i < cnt; i++) send_byte(probe_buf[i], i == cnt - 1);
    probe_buf.delete();
    probes_sent++;
  endtask

  task automatic push_magic();
    for (int i = 3; i >= 0; i--) probe_buf.push_back(edp_pkg::EBML_MAGIC[8 * i +: 8]);
  endtask

  // EBML variable-length size: marker bit at position 7*n, value below it.
  task automatic push_size(input int n, input logic [55:0] val);
    logic [63:0] enc;
    enc = (64'd1 << (7 * n)) | {8'd0, val};
    for (int i = n - 1; i >= 0; i--) probe_buf.push_back(enc[8 * i +: 8]);
  endtask

  task automatic gen_random_probe();
    int          kind;
    int          n;
    int          body_len;
    int          doc_at;
    int          doc_len;
    int          stop_at;
    int          k;
    logic [7:0]  b;
    logic [7:0]  body[0:199];
    logic [63:0] doc;
    logic [63:0] big;
    kind = $urandom_range(0, 99);
    sender_calm = ($urandom_range(0, 3) == 0);
    if (kind < 60) begin
      n = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, MAX_LEN);
      case ($urandom_range(0, 3))
        0:       body_len = $urandom_range(0, 4);
        1, 2:    body_len = $urandom_range(5, 24);
        default: body_len = $urandom_range(25, (n == 1) ? 127 : 180);
      endcase
      for (int i = 0; i < 200; i++) body[i] = 8'($urandom_range(0, 255));
      // The doctype may land wholly inside, across the end of, or past the header.
      doc_at = $urandom_range(0, body_len);
      doc_len = 0;
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          doc = edp_pkg::DOC_LONG;
          doc_len = 8;
        end else begin
          doc = {32'd0, edp_pkg::DOC_SHORT};
          doc_len = 4;
        end
        for (int i = 0; i < doc_len; i++) body[doc_at + i] = doc[8 * (doc_len - 1 - i) +: 8];
      end
      push_magic();
      push_size(n, 56'(body_len));
      stop_at = body_len + $urandom_range(0, 3);
      if (doc_at + doc_len > stop_at) stop_at = doc_at + doc_len;
      for (int i = 0; i < stop_at; i++) probe_buf.push_back(body[i]);
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, probe_buf.size() - 1)) void'(probe_buf.pop_back());
    end else if (kind < 75) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) probe_buf.push_back(edp_pkg::EBML_MAGIC[8 * (3 - i) +: 8]);
      b = 8'($urandom_range(0, 255));
      if (b == edp_pkg::EBML_MAGIC[8 * (3 - k) +: 8]) b = b ^ (8'd1 << $urandom_range(0, 7));
      probe_buf.push_back(b);
      repeat ($urandom_range(0, 4)) probe_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      push_magic();
      if ($urandom_range(0, 2) == 0) begin
        probe_buf.push_back(8'h00);
      end else begin
        n = $urandom_range(2, MAX_LEN);
        big = {$urandom, $urandom};
        push_size(n, big[55:0] & ((56'd1 << (7 * n)) - 56'd1));
      end
      repeat ($urandom_range(0, 10)) probe_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) probe_buf.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) probe_buf[0] = edp_pkg::EBML_MAGIC[31:24];
    end
    flush_probe();
  endtask

  task automatic test_directed_cases();
    probe_buf.push_back(8'hFF);
    flush_probe();
    push_magic();
    probe_buf.push_back(8'h00);
    flush_probe();
    // Empty header body, then a byte after the verdict that must be ignored.
    push_magic();
    push_size(1, 56'd0);
    probe_buf.push_back(8'h5A);
    flush_probe();
    push_magic();
    push_size(1, 56'd4);
    for (int i = 3; i >= 0; i--) probe_buf.push_back(edp_pkg::DOC_SHORT[8 * i +: 8]);
    flush_probe();
    probe_buf.push_back(edp_pkg::EBML_MAGIC[31:24]);
    probe_buf.push_back(edp_pkg::EBML_MAGIC[23:16]);
    flush_probe();
  endtask

  task automatic test_random_probes();
    while (bytes_sent < 900) gen_random_probe();
  endtask

  task automatic test_steady_stream();
    int target;
    target = bytes_sent + 150;
    steady = 1'b1;
    while (bytes_sent < target) gen_random_probe();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with none expected", out_verdict));
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (out_verdict !== want_verdict)
          report_mismatch($sformatf("verdict %0d, expected %0d", out_verdict, want_verdict));
        verdict_tally[want_verdict]++;
      end
    end
  end

  // Result-side backpressure in random bursts; always ready once steady is set.
  initial begin
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 14);
      end
      for (int i = 1; i < n && !steady; i++) @(posedge clk);
    end
  end

  initial begin
    #8_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    err_count   = 0;
    bytes_sent  = 0;
    probes_sent = 0;
    steady      = 1'b0;
    sender_calm = 1'b0;
    for (int i = 0; i < 4; i++) verdict_tally[i] = 0;
    clear_probe();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'd0;
    in_last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_probes();
    test_steady_stream();

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("summary: %0d probes, %0d bytes accepted", probes_sent, bytes_sent);
    $display("summary: verdicts rejected %0d, unknown doctype %0d, matroska/webm %0d",
             verdict_tally[edp_pkg::VERDICT_REJECT], verdict_tally[edp_pkg::VERDICT_EBML],
             verdict_tally[edp_pkg::VERDICT_MKV]);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/edp_pkg.sv
sv/ebml_doctype_probe_core.sv
tb/tb_top.sv
